// ===== rtl/epms_pkg.sv =====
// Shared constants, command codes and the stage record of the exact pattern match stream unit.
`timescale 1ns / 1ps

package epms_pkg;

   localparam int MAX_PATTERN_DEFAULT = 64;
   localparam int BYTE_W              = 8;
   localparam int INDEX_W             = 6;
   localparam int LENGTH_W            = 7;
   localparam int POS_W               = 32;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_TEXT    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_UNUSED  = 2'd3
   } epms_cmd_type;

   typedef struct packed {
      logic             valid;
      logic             fill_ok;
      logic [POS_W-1:0] pos;
   } epms_stage_type;

endpackage

// ===== rtl/epms_cell.sv =====
// One cell of the match row: a text byte, a pattern byte and the registered compare result.
`timescale 1ns / 1ps

module epms_cell
   import epms_pkg::*;
(
   input  logic              clock,
   input  logic              load_en,
   input  logic [BYTE_W-1:0] load_byte,
   input  logic              rotate_en,
   input  logic [BYTE_W-1:0] rotate_in,
   input  logic              shift_en,
   input  logic [BYTE_W-1:0] shift_in,
   output logic [BYTE_W-1:0] window_out,
   output logic [BYTE_W-1:0] pattern_out,
   output logic              hit_out
);

   logic [BYTE_W-1:0] window_ff;
   logic [BYTE_W-1:0] window_in;
   logic [BYTE_W-1:0] pattern_ff;
   logic [BYTE_W-1:0] pattern_in;
   logic              hit_ff;
   logic              hit_in;

   always_comb begin
      window_in  = window_ff;
      pattern_in = pattern_ff;
      hit_in     = hit_ff;
      if (shift_en) begin
         window_in = shift_in;
         hit_in    = (shift_in == pattern_ff);
      end
      if (load_en) begin
         pattern_in = load_byte;
      end else if (rotate_en) begin
         pattern_in = rotate_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff  <= window_in;
      pattern_ff <= pattern_in;
      hit_ff     <= hit_in;
   end

   assign window_out  = window_ff;
   assign pattern_out = pattern_ff;
   assign hit_out     = hit_ff;

endmodule

// ===== rtl/epms_out.sv =====
// Reduction of the cell compare results and the registered result stage.
`timescale 1ns / 1ps

module epms_out
   import epms_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  epms_stage_type         stage,
   input  logic [MAX_PATTERN-1:0] hits,
   input  logic [LEN_W-1:0]       active,
   output logic                   move,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [POS_W-1:0]       rsp_tdata   // match_start[31:0]
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [POS_W-1:0]       data_ff;
   logic [POS_W-1:0]       data_in;
   logic [MAX_PATTERN-1:0] mask;
   logic                   all_hit;

   always_comb begin
      for (int c = 0; c < MAX_PATTERN; c++) begin
         mask[c] = (c < 32'(active));
      end
   end

   assign all_hit = &(hits | ~mask);
   assign move    = stage.valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (move) begin
         valid_in = stage.fill_ok && all_hit;
         data_in  = stage.pos - POS_W'(active) + POS_W'(1);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== rtl/exact_pattern_match_stream_unit.sv =====
// Top level of the exact pattern match stream unit: control, the cell row and the result stage.
`timescale 1ns / 1ps

// The unit takes one transaction per clock cycle while req_tready is high and reports, for each
// text byte that completes an exact occurrence of the loaded pattern, the zero-based start
// position of that occurrence. A result passes through the compare stage register and then the
// result register. The pattern is held in a ring of MAX_PATTERN cells lined up against the
// newest text bytes; after a write of pattern_length the ring rotates one cell per cycle into its
// new alignment, and the input stalls until it is aligned before the next transaction is taken.

module exact_pattern_match_stream_unit
   import epms_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [LENGTH_W-1:0] csr_wr_data,  // pattern_length[6:0]
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,    // pattern_index[5:0], byte_value[13:6], zero[15:14]
   input  logic [1:0]          req_tuser,    // cmd[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [POS_W-1:0]    rsp_tdata     // match_start[31:0]
);

   localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

   epms_cmd_type          cmd;
   logic [INDEX_W-1:0]    req_index;
   logic [BYTE_W-1:0]     req_byte;

   logic [LENGTH_W-1:0]   len_ff;
   logic [LENGTH_W-1:0]   len_in;
   logic [IDX_W-1:0]      align_ff;
   logic [IDX_W-1:0]      align_in;
   logic [LEN_W-1:0]      fill_ff;
   logic [LEN_W-1:0]      fill_in;
   logic [LEN_W-1:0]      fill_next;
   logic [POS_W-1:0]      pos_ff;
   logic [POS_W-1:0]      pos_in;
   epms_stage_type        stage_ff;
   epms_stage_type        stage_in;

   logic [31:0]           active32;
   logic [31:0]           target32;
   logic [31:0]           index32;
   logic [31:0]           cell32;
   logic [LEN_W-1:0]      active;
   logic [IDX_W-1:0]      target;
   logic [IDX_W-1:0]      load_cell;
   logic                  load_ok;
   logic                  aligned;
   logic                  accept;
   logic                  text_acc;
   logic                  load_acc;
   logic                  restart_acc;
   logic                  move;

   logic [BYTE_W-1:0]      window [MAX_PATTERN];
   logic [BYTE_W-1:0]      pattern [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] hits;

   assign cmd       = epms_cmd_type'(req_tuser);
   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_byte  = req_tdata[INDEX_W+BYTE_W-1:INDEX_W];

   always_comb begin
      active32 = 32'(len_ff);
      if (active32 == 32'd0) begin
         active32 = 32'd1;
      end else if (active32 > 32'(MAX_PATTERN)) begin
         active32 = 32'(MAX_PATTERN);
      end
      target32 = active32 - 32'd1;
      index32  = 32'(req_index);
      if (index32 <= target32) begin
         cell32 = target32 - index32;
      end else begin
         cell32 = target32 + 32'(MAX_PATTERN) - index32;
      end
   end

   assign active    = active32[LEN_W-1:0];
   assign target    = target32[IDX_W-1:0];
   assign load_cell = cell32[IDX_W-1:0];
   assign load_ok   = (index32 < 32'(MAX_PATTERN));
   assign aligned   = (align_ff == target);

   assign req_tready  = aligned && (!stage_ff.valid || move);
   assign accept      = req_tvalid && req_tready;
   assign text_acc    = accept && (cmd == CMD_TEXT);
   assign load_acc    = accept && (cmd == CMD_LOAD) && load_ok;
   assign restart_acc = accept && (cmd == CMD_RESTART);

   assign fill_next = (32'(fill_ff) < 32'(MAX_PATTERN)) ? fill_ff + LEN_W'(1) : fill_ff;

   always_comb begin
      len_in   = len_ff;
      align_in = align_ff;
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      stage_in = stage_ff;
      if (csr_wr_en) begin
         len_in = csr_wr_data;
      end
      if (!aligned) begin
         if (32'(align_ff) == 32'(MAX_PATTERN - 1)) begin
            align_in = '0;
         end else begin
            align_in = align_ff + IDX_W'(1);
         end
      end
      if (move) begin
         stage_in.valid = 1'b0;
      end
      if (text_acc) begin
         fill_in          = fill_next;
         pos_in           = (pos_ff == '1) ? pos_ff : pos_ff + POS_W'(1);
         stage_in.valid   = 1'b1;
         stage_in.fill_ok = (32'(fill_next) >= active32);
         stage_in.pos     = pos_ff;
      end else if (restart_acc) begin
         fill_in = '0;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= LENGTH_W'(1);
         align_ff       <= '0;
         fill_ff        <= '0;
         pos_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         len_ff         <= len_in;
         align_ff       <= align_in;
         fill_ff        <= fill_in;
         pos_ff         <= pos_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.fill_ok <= stage_in.fill_ok;
      stage_ff.pos     <= stage_in.pos;
   end

   for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_cell
      logic [BYTE_W-1:0] shift_src;
      if (c == 0) begin : g_head
         assign shift_src = req_byte;
      end else begin : g_body
         assign shift_src = window[c-1];
      end

      epms_cell u_cell (
         .clock       (clock),
         .load_en     (load_acc && (load_cell == IDX_W'(c))),
         .load_byte   (req_byte),
         .rotate_en   (!aligned),
         .rotate_in   (pattern[(c + MAX_PATTERN - 1) % MAX_PATTERN]),
         .shift_en    (text_acc),
         .shift_in    (shift_src),
         .window_out  (window[c]),
         .pattern_out (pattern[c]),
         .hit_out     (hits[c])
      );
   end

   epms_out #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage_ff),
      .hits       (hits),
      .active     (active),
      .move       (move),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The pattern ring must be in line with the current length whenever a transaction is taken.
   assert property (@(posedge clock) disable iff (reset) accept |-> aligned)
      else $error("Transaction accepted while the pattern ring was still rotating.");

   // A text byte may only enter the compare stage when its previous contents leave it.
   assert property (@(posedge clock) disable iff (reset) (text_acc && stage_ff.valid) |-> move)
      else $error("Compare stage overwritten before it was consumed.");

   // The fill count never passes the depth of the window.
   assert property (@(posedge clock) disable iff (reset) 32'(fill_ff) <= 32'(MAX_PATTERN))
      else $error("Window fill count beyond the window depth.");

   // A restart leaves an empty window and position zero behind it.
   assert property (@(posedge clock) disable iff (reset)
      restart_acc |=> (fill_ff == '0) && (pos_ff == '0))
      else $error("Restart did not clear the window fill and position.");

endmodule

// ===== dv/epms_match_check_pkg.sv =====
// Scoreboard class for the exact pattern match stream unit: text window tracking and match checks.
`timescale 1ns / 1ps

package epms_match_check_pkg;

   import epms_pkg::*;

   class match_scoreboard;

      logic [BYTE_W-1:0]   pattern_bytes [MAX_PATTERN_DEFAULT];
      logic [BYTE_W-1:0]   recent_text [MAX_PATTERN_DEFAULT];
      logic [POS_W-1:0]    next_position;
      int unsigned         window_count;
      logic [LENGTH_W-1:0] length_reg;
      logic [POS_W-1:0]    expected_starts [$];
      int unsigned         failures;

      function new();
         foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
         foreach (recent_text[i]) recent_text[i] = '0;
         next_position = '0;
         window_count  = 0;
         length_reg    = LENGTH_W'(1);
         failures      = 0;
      endfunction

      function void set_length(logic [LENGTH_W-1:0] value);
         length_reg = value;
      endfunction

      function int unsigned pending();
         return expected_starts.size();
      endfunction

      // Updates the model for one accepted request transaction and works out the match, if any, it causes.
      function void note_request(epms_cmd_type cmd, logic [INDEX_W-1:0] index,
                                 logic [BYTE_W-1:0] value);
         int unsigned      span;
         int               i;
         logic [POS_W-1:0] start_pos;
         bit               hit;
         case (cmd)
            CMD_LOAD: pattern_bytes[index] = value;
            CMD_RESTART: begin
               foreach (recent_text[k]) recent_text[k] = '0;
               next_position = '0;
               window_count  = 0;
            end
            CMD_TEXT: begin
               span = length_reg;
               if (span < 1) span = 1;
               if (span > MAX_PATTERN_DEFAULT) span = MAX_PATTERN_DEFAULT;
               start_pos = next_position;
               for (i = MAX_PATTERN_DEFAULT - 1; i > 0; i--) recent_text[i] = recent_text[i-1];
               recent_text[0] = value;
               if (window_count < MAX_PATTERN_DEFAULT) window_count++;
               if (next_position != '1) next_position++;
               if (window_count >= span) begin
                  hit = 1'b1;
                  for (i = 0; i < span; i++) begin
                     if (recent_text[i] != pattern_bytes[span-1-i]) hit = 1'b0;
                  end
                  if (hit) expected_starts.push_back(start_pos - POS_W'(span - 1));
               end
            end
            default: ;
         endcase
      endfunction

      function void report(string what);
         failures++;
         if (failures <= 10) $display("%0t: %s", $time, what);
      endfunction

      function void check_match(logic [POS_W-1:0] got);
         logic [POS_W-1:0] want;
         if (expected_starts.size() == 0) begin
            report($sformatf("unexpected match_start %0d", got));
         end else begin
            want = expected_starts.pop_front();
            if (want != got) report($sformatf("match_start expected %0d, got %0d", want, got));
         end
      endfunction

   endclass

endpackage

// ===== dv/tb_exact_pattern_match_stream_unit.sv =====
// Testbench top for the exact pattern match stream unit: stimulus, flow control and checking.
`timescale 1ns / 1ps

module tb_exact_pattern_match_stream_unit;

   import epms_pkg::*;
   import epms_match_check_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int TEXT_TARGET = 1850;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [LENGTH_W-1:0] csr_wr_data = '0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata   = '0;
   logic [1:0]          req_tuser   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [POS_W-1:0]    rsp_tdata;

   match_scoreboard sb = new();

   logic [BYTE_W-1:0] pattern_copy [MAX_PATTERN_DEFAULT];
   int unsigned       burst_left     = 0;
   int unsigned       accepted_count = 0;
   int unsigned       cur_length     = 1;
   bit                hold_request   = 1'b0;
   bit                narrow         = 1'b0;
   logic [BYTE_W-1:0] alpha_base     = '0;

   exact_pattern_match_stream_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_match(rsp_tdata);
   end

   // The receiver stalls on a pattern of its own and holds off completely when asked.
   initial begin
      int unsigned mode;
      int unsigned left;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(30, 200);
            end
            left--;
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = ($urandom_range(0, 3) != 0);
               2: rsp_tready = ($urandom_range(0, 2) == 0);
               default: rsp_tready = (left % 4 == 0);
            endcase
         end
      end
   end

   task automatic send_txn(input epms_cmd_type cmd, input logic [INDEX_W-1:0] index,
                           input logic [BYTE_W-1:0] value);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {2'b00, value, index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, index, value);
      if (cmd == CMD_LOAD) pattern_copy[index] = value;
      if (cmd != CMD_UNUSED) accepted_count++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_length(input int unsigned value);
      settle();
      csr_wr_data = LENGTH_W'(value);
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_length(LENGTH_W'(value));
      cur_length = value;
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      if (narrow) return alpha_base + BYTE_W'($urandom_range(0, 1));
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [INDEX_W-1:0] any_index();
      return INDEX_W'($urandom_range(0, 63));
   endfunction

   task automatic run_phase(input int unsigned length);
      int          i;
      int unsigned kind;
      int unsigned flip;
      bit          upward;
      narrow     = ($urandom_range(0, 9) < 7);
      alpha_base = BYTE_W'($urandom_range(0, 254));
      if (length != cur_length || $urandom_range(0, 3) == 0) write_length(length);
      upward = $urandom_range(0, 1);
      for (i = 0; i < length; i++) begin
         send_txn(CMD_LOAD, INDEX_W'(upward ? i : length - 1 - i), pick_byte());
      end
      if ($urandom_range(0, 3) == 0) send_txn(CMD_LOAD, any_index(), BYTE_W'($urandom));
      if ($urandom_range(0, 1) == 0) send_txn(CMD_RESTART, any_index(), BYTE_W'($urandom));
      repeat ($urandom_range(4, 16)) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            flip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, length - 1) : length;
            for (i = 0; i < length; i++) begin
               send_txn(CMD_TEXT, any_index(),
                        (i == flip) ? pattern_copy[i] ^ (8'h01 << $urandom_range(0, 7))
                                    : pattern_copy[i]);
            end
         end else if (kind < 88) begin
            repeat ($urandom_range(1, length + 2)) send_txn(CMD_TEXT, any_index(), pick_byte());
         end else if (kind < 94) begin
            send_txn(CMD_RESTART, any_index(), BYTE_W'($urandom));
         end else if (kind < 97) begin
            send_txn(CMD_UNUSED, any_index(), BYTE_W'($urandom));
         end else begin
            send_txn(CMD_LOAD, any_index(), pick_byte());
         end
      end
   endtask

   // With a one-byte pattern every text byte matches, so a long receiver hold-off fills the
   // result path and the input has to stall.
   task automatic fill_up();
      write_length(1);
      send_txn(CMD_LOAD, '0, 8'h5A);
      burst_left   = 100000;
      hold_request = 1'b1;
      repeat (120) send_txn(CMD_TEXT, any_index(), 8'h5A);
      burst_left = 0;
   endtask

   initial begin
      int unsigned pick;
      bit          pressure_done;
      pressure_done = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_length(1);
      send_txn(CMD_LOAD, 6'd0, 8'hFF);
      send_txn(CMD_LOAD, 6'd63, 8'h00);
      send_txn(CMD_TEXT, 6'd0, 8'hFF);
      send_txn(CMD_TEXT, 6'd63, 8'h00);
      send_txn(CMD_TEXT, 6'd21, 8'hFF);
      send_txn(CMD_UNUSED, 6'd63, 8'hFF);
      send_txn(CMD_RESTART, 6'd42, 8'hAA);
      send_txn(CMD_TEXT, 6'd0, 8'hFF);
      write_length(3);
      send_txn(CMD_LOAD, 6'd0, 8'h41);
      send_txn(CMD_LOAD, 6'd1, 8'h42);
      send_txn(CMD_LOAD, 6'd2, 8'h41);
      send_txn(CMD_RESTART, 6'd0, 8'h00);
      send_txn(CMD_TEXT, 6'd0, 8'h41);
      send_txn(CMD_TEXT, 6'd0, 8'h42);
      send_txn(CMD_TEXT, 6'd0, 8'h41);
      send_txn(CMD_TEXT, 6'd0, 8'h42);
      send_txn(CMD_TEXT, 6'd0, 8'h41);
      write_length(2);
      send_txn(CMD_LOAD, 6'd0, 8'h00);
      send_txn(CMD_LOAD, 6'd1, 8'h00);
      send_txn(CMD_RESTART, 6'd0, 8'h00);
      send_txn(CMD_TEXT, 6'd0, 8'h00);
      send_txn(CMD_TEXT, 6'd0, 8'h00);

      accepted_count = 0;
      run_phase(64);
      while (accepted_count < TEXT_TARGET) begin
         if (!pressure_done && accepted_count > TEXT_TARGET / 2) begin
            fill_up();
            pressure_done = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0) run_phase(1);
         else if (pick == 1) run_phase(64);
         else if (pick < 5) run_phase($urandom_range(1, 64));
         else run_phase($urandom_range(1, 6));
      end

      settle();
      repeat (20) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/epms_pkg.sv
rtl/epms_cell.sv
rtl/epms_out.sv
rtl/exact_pattern_match_stream_unit.sv
dv/epms_match_check_pkg.sv
dv/tb_exact_pattern_match_stream_unit.sv
